### hdl/bdlp_pkg.sv
package bdlp_pkg;

  // Default counter width
  localparam int TimeBitsDef = 17;

  // Register widths
  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 2;

  // Register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEBOUNCE_MS    = 2'd0,
    CFG_LONG_PRESS_MS  = 2'd1,
    CFG_EVENTS_ENABLED = 2'd2
  } cfg_idx_t;

  // Register reset values
  localparam logic [CfgDataW-1:0] DebounceMsRst  = 16'd10;
  localparam logic [CfgDataW-1:0] LongPressMsRst = 16'd1000;
  localparam logic                EventsEnRst    = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] long_press_ms;
    logic                events_enabled;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic pressed;
    logic released;
    logic long_once;
    logic long_held;
  } evt_t;

endpackage

### hdl/bdlp_cfg.sv
module bdlp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bdlp_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]    cfg_wdata,
  output bdlp_pkg::cfg_t                   cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_r;

  // Register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DebounceMsRst;
      cfg_r.long_press_ms  <= LongPressMsRst;
      cfg_r.events_enabled <= EventsEnRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:    cfg_r.debounce_ms    <= cfg_wdata;
        CFG_LONG_PRESS_MS:  cfg_r.long_press_ms  <= cfg_wdata;
        CFG_EVENTS_ENABLED: cfg_r.events_enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

### hdl/bdlp_core.sv
module bdlp_core #(
  parameter int TIME_BITS = bdlp_pkg::TimeBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            raw,
  input  bdlp_pkg::cfg_t  cfg,
  output bdlp_pkg::evt_t  evt
);
  import bdlp_pkg::*;

  localparam int CmpW = (TIME_BITS > CfgDataW) ? TIME_BITS : CfgDataW;
  localparam logic [TIME_BITS-1:0] CntMax = {TIME_BITS{1'b1}};

  logic                 last_raw_r, last_raw_nxt;
  logic                 prev_q_r, prev_q_nxt;
  logic                 hold_act_r, hold_act_nxt;
  logic                 long_det_r, long_det_nxt;
  logic [TIME_BITS-1:0] stable_r, stable_nxt;
  logic [TIME_BITS-1:0] hold_r, hold_nxt;

  logic [TIME_BITS-1:0] stable_inc, hold_inc;
  logic                 gate;
  logic                 hold_act_mid, long_mid;

  // Saturating increments
  assign stable_inc = (stable_r == CntMax) ? stable_r : stable_r + 1'b1;
  assign hold_inc   = (hold_r == CntMax) ? hold_r : hold_r + 1'b1;

  // Next state and events for one tick
  always_comb begin
    last_raw_nxt = last_raw_r;
    prev_q_nxt   = prev_q_r;
    hold_act_nxt = hold_act_r;
    long_det_nxt = long_det_r;
    stable_nxt   = stable_inc;
    hold_nxt     = hold_inc;
    hold_act_mid = hold_act_r;
    long_mid     = long_det_r;
    gate         = 1'b0;
    evt          = '0;
    if (cfg.events_enabled) begin
      // raw change restarts the stable counter
      if (raw != last_raw_r) begin
        stable_nxt = '0;
      end
      last_raw_nxt = raw;
      gate = CmpW'(stable_nxt) > CmpW'(cfg.debounce_ms);
      if (gate) begin
        evt.pressed  = prev_q_r & ~raw;
        evt.released = ~prev_q_r & raw;
        if (evt.pressed) begin
          hold_act_mid = 1'b1;
          long_mid     = 1'b0;
          hold_nxt     = '0;
        end else if (evt.released) begin
          hold_act_mid = 1'b0;
          long_mid     = 1'b0;
        end
        prev_q_nxt    = raw;
        evt.long_once = hold_act_mid & ~long_mid &
                        (CmpW'(hold_nxt) > CmpW'(cfg.long_press_ms));
        hold_act_nxt  = hold_act_mid;
        long_det_nxt  = long_mid | evt.long_once;
        evt.long_held = long_det_nxt;
      end
    end
  end

  // Tracker state, advanced once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      prev_q_r   <= 1'b1;
      hold_act_r <= 1'b0;
      long_det_r <= 1'b0;
      stable_r   <= '0;
      hold_r     <= '0;
    end else if (step) begin
      last_raw_r <= last_raw_nxt;
      prev_q_r   <= prev_q_nxt;
      hold_act_r <= hold_act_nxt;
      long_det_r <= long_det_nxt;
      stable_r   <= stable_nxt;
      hold_r     <= hold_nxt;
    end
  end

endmodule

### hdl/button_debounce_long_press.sv
// Pipeline: 2 register stages, the input register and then the result register; a
// result beat is loaded into the result register from the input register on a step.
// Throughput: one tick per cycle unless out_ready stalls; the input register and
// result register each take a new beat when the stage after them is empty or draining.
// Reset (rst_n low, synchronous): both stages empty, tracker state idle,
// registers back to debounce 10, long press 1000, events enabled.
module button_debounce_long_press #(
  parameter int TIME_BITS = bdlp_pkg::TimeBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_raw_level,
  // event output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_pressed,
  output logic                            out_released,
  output logic                            out_long_once,
  output logic                            out_long_held,
  // register writes
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [bdlp_pkg::CfgDataW-1:0]   cfg_wdata
);
  import bdlp_pkg::*;

  cfg_t cfg;
  evt_t evt;
  evt_t evt_r;
  logic in_v_r;
  logic raw_r;
  logic out_v_r;
  logic advance;
  logic step;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Handshake: result stage frees when empty or taken
  assign advance  = ~out_v_r | out_ready;
  assign step     = in_v_r & advance;
  assign in_ready = ~in_v_r | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r <= in_raw_level;
    end
  end

  bdlp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .raw   (raw_r),
    .cfg   (cfg),
    .evt   (evt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      evt_r <= evt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pressed   = evt_r.pressed;
  assign out_released  = evt_r.released;
  assign out_long_once = evt_r.long_once;
  assign out_long_held = evt_r.long_held;

  // A first long-press beat always reports the held flag
  a_once_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_long_once || out_long_held))
    else $error("long_once without long_held");

  // Press, release and long-press recognition are mutually exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_pressed, out_released, out_long_once}) <= 1)
    else $error("conflicting events in one beat");

  // Reset empties the result stage
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
